/* design/pth_pkg.sv */
`timescale 1ns / 1ps

package pth_pkg;

    // field widths
    localparam int TGT_W     = 10;
    localparam int GAIN_W    = 20;
    localparam int LIM_W     = 11;
    localparam int WIN_W     = 8;
    localparam int TURN_W    = 24;
    localparam int PCT_W     = 7;
    localparam int ANGLE_W   = 6;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 24;

    // datapath widths
    localparam int TEMP_EXT_W = 17;  // holds any temperature up to 16 bits plus the range limits
    localparam int ERR_W      = 13;
    localparam int SUM_W      = 12;
    localparam int MUL_A_W    = GAIN_W + 1;
    localparam int MUL_B_W    = 16;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int ACC_W      = PROD_W + 1;

    // constants of the control law
    localparam int TEMP_LO_EXCL = 80;    // 5 C
    localparam int TEMP_HI_EXCL = 960;   // 60 C
    localparam int FAIL_TEMP    = -1584; // -99 C
    localparam int PCT_MAX      = 100;
    // floor(x / 100) == (x * 5243) >> 19 for x below 43690
    localparam int RECIP100     = 5243;
    localparam int RECIP_SHIFT  = 19;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET_TEMP    = 3'd0,
        REG_KP_GAIN        = 3'd1,
        REG_KI_GAIN        = 3'd2,
        REG_KD_GAIN        = 3'd3,
        REG_INTEGRAL_LIMIT = 3'd4,
        REG_WINDOW_TICKS   = 3'd5,
        REG_TURN_INTERVAL  = 3'd6
    } t_reg;

    // microcode
    localparam int PC_W = 4;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_TICK,    // relay drive, window count
        OP_LOADE,   // error against setpoint
        OP_ERR,     // integral with clamp, derivative
        OP_MULP,    // prod = kp * e
        OP_MULI,    // acc = prod, prod = ki * sum
        OP_MULD,    // acc += prod, prod = kd * d
        OP_SUM,     // acc += prod
        OP_PCT,     // scale and saturate drive level
        OP_ONMUL,   // prod = pct * window
        OP_ONDIV,   // prod = prod * reciprocal of 100
        OP_ONSET,   // on ticks from prod
        OP_OFF,     // heater off, temperature out of range
        OP_FIN      // turner, sample store, result beat
    } t_op;

    typedef enum logic [2:0] {
        JMP_NEXT,
        JMP_ALWAYS,
        JMP_NO_BEAT,
        JMP_NO_WEND,
        JMP_OUT_RANGE,
        JMP_OUT_BUSY
    } t_cond;

    typedef struct packed {
        t_op              op;
        t_cond            cond;
        logic [PC_W-1:0]  target;
    } t_uword;

    localparam logic [PC_W-1:0] PC_IDLE  = 4'd0;
    localparam logic [PC_W-1:0] PC_TICK  = 4'd1;
    localparam logic [PC_W-1:0] PC_CHK   = 4'd2;
    localparam logic [PC_W-1:0] PC_RNG   = 4'd3;
    localparam logic [PC_W-1:0] PC_ERR   = 4'd4;
    localparam logic [PC_W-1:0] PC_MULP  = 4'd5;
    localparam logic [PC_W-1:0] PC_MULI  = 4'd6;
    localparam logic [PC_W-1:0] PC_MULD  = 4'd7;
    localparam logic [PC_W-1:0] PC_SUM   = 4'd8;
    localparam logic [PC_W-1:0] PC_PCT   = 4'd9;
    localparam logic [PC_W-1:0] PC_ONMUL = 4'd10;
    localparam logic [PC_W-1:0] PC_ONDIV = 4'd11;
    localparam logic [PC_W-1:0] PC_ONSET = 4'd12;
    localparam logic [PC_W-1:0] PC_OFF   = 4'd13;
    localparam logic [PC_W-1:0] PC_SPARE = 4'd14;
    localparam logic [PC_W-1:0] PC_FIN   = 4'd15;  // falls through to idle on wrap

    // control store
    function automatic t_uword ucode(input logic [PC_W-1:0] pc);
        t_uword w;
        w = '{op: OP_NOP, cond: JMP_NEXT, target: PC_IDLE};
        unique case (pc)
            PC_IDLE:  w = '{op: OP_NOP,   cond: JMP_NO_BEAT,   target: PC_IDLE};
            PC_TICK:  w = '{op: OP_TICK,  cond: JMP_NEXT,      target: PC_IDLE};
            PC_CHK:   w = '{op: OP_NOP,   cond: JMP_NO_WEND,   target: PC_FIN};
            PC_RNG:   w = '{op: OP_LOADE, cond: JMP_OUT_RANGE, target: PC_OFF};
            PC_ERR:   w = '{op: OP_ERR,   cond: JMP_NEXT,      target: PC_IDLE};
            PC_MULP:  w = '{op: OP_MULP,  cond: JMP_NEXT,      target: PC_IDLE};
            PC_MULI:  w = '{op: OP_MULI,  cond: JMP_NEXT,      target: PC_IDLE};
            PC_MULD:  w = '{op: OP_MULD,  cond: JMP_NEXT,      target: PC_IDLE};
            PC_SUM:   w = '{op: OP_SUM,   cond: JMP_NEXT,      target: PC_IDLE};
            PC_PCT:   w = '{op: OP_PCT,   cond: JMP_NEXT,      target: PC_IDLE};
            PC_ONMUL: w = '{op: OP_ONMUL, cond: JMP_NEXT,      target: PC_IDLE};
            PC_ONDIV: w = '{op: OP_ONDIV, cond: JMP_NEXT,      target: PC_IDLE};
            PC_ONSET: w = '{op: OP_ONSET, cond: JMP_ALWAYS,    target: PC_FIN};
            PC_OFF:   w = '{op: OP_OFF,   cond: JMP_ALWAYS,    target: PC_FIN};
            PC_SPARE: w = '{op: OP_NOP,   cond: JMP_ALWAYS,    target: PC_IDLE};
            PC_FIN:   w = '{op: OP_FIN,   cond: JMP_OUT_BUSY,  target: PC_FIN};
            default:  w = '{op: OP_NOP,   cond: JMP_ALWAYS,    target: PC_IDLE};
        endcase
        return w;
    endfunction

endpackage

/* design/pid_time_proportional_heater.sv */
`timescale 1ns / 1ps

// Incubator heater controller with tray turner. Each input beat is one 10 ms tick and
// yields exactly one result beat. The relay is on while the tick position in the
// current window is below the on-tick count; at each window end a fixed-point PID
// (temperature in 1/16 C, gains in percent per C with GAIN_FRAC_BITS fraction bits)
// sets the drive level, or switches the heater off when the last temperature is not
// strictly between 5 C and 60 C. A new sample takes effect at the next window end.
// A button press or the turn timer toggles the tray side. Control runs from a
// 16-word microcode table over one shared 21x16 multiplier, one item at a time: a tick
// runs the tick, window-end check and wrap-up steps, a window end also the range check
// and either the off step or the error, multiply, accumulate and scaling steps of the PID.
// The result beat waits for i_ready. The user must write configuration through
// i_cfg_we / i_cfg_idx / i_cfg_data only while idle; the block does not enforce it.
module pid_time_proportional_heater #(
    parameter int TEMP_WIDTH     = 12,
    parameter int GAIN_FRAC_BITS = 8,
    parameter int RIGHT_ANGLE    = 60
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // configuration
    input  logic                                   i_cfg_we,
    input  logic [pth_pkg::CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [pth_pkg::CFG_W-1:0]              i_cfg_data,
    // tick input
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic                                   i_sample_present,
    input  logic                                   i_sample_ok,
    input  logic signed [TEMP_WIDTH-1:0]           i_temperature,
    input  logic                                   i_button_press,
    // result output
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic                                   o_heater_on,
    output logic [pth_pkg::PCT_W-1:0]              o_heater_percent,
    output logic                                   o_turn_side,
    output logic [pth_pkg::ANGLE_W-1:0]            o_turn_angle,
    output logic [pth_pkg::TURN_W-1:0]             o_turn_age
);

    localparam int TEMP_MIN  = -(2 ** (TEMP_WIDTH - 1));
    localparam int FAIL_VAL  = (pth_pkg::FAIL_TEMP < TEMP_MIN) ? TEMP_MIN : pth_pkg::FAIL_TEMP;
    localparam logic signed [TEMP_WIDTH-1:0] FAIL_CODE = TEMP_WIDTH'(FAIL_VAL);
    localparam int PCT_SHIFT = GAIN_FRAC_BITS + 4;
    localparam logic [pth_pkg::ANGLE_W-1:0] ANGLE_RIGHT = pth_pkg::ANGLE_W'(RIGHT_ANGLE);
    localparam int EXT_PAD   = pth_pkg::TEMP_EXT_W - TEMP_WIDTH;

    // configuration registers
    logic [pth_pkg::TGT_W-1:0]   r_target;
    logic [pth_pkg::GAIN_W-1:0]  r_kp;
    logic [pth_pkg::GAIN_W-1:0]  r_ki;
    logic [pth_pkg::GAIN_W-1:0]  r_kd;
    logic [pth_pkg::LIM_W-1:0]   r_limit;
    logic [pth_pkg::WIN_W-1:0]   r_window;
    logic [pth_pkg::TURN_W-1:0]  r_interval;

    // control state
    logic [pth_pkg::PC_W-1:0]    r_pc;
    logic signed [TEMP_WIDTH-1:0] r_latest;
    logic signed [pth_pkg::SUM_W-1:0] r_esum;
    logic signed [pth_pkg::ERR_W-1:0] r_last_err;
    logic [pth_pkg::WIN_W-1:0]   r_on;
    logic [pth_pkg::WIN_W-1:0]   r_wc;
    logic [pth_pkg::PCT_W-1:0]   r_pct;
    logic [pth_pkg::TURN_W-1:0]  r_turn;
    logic                        r_side;
    logic                        r_ovalid;

    // scratch and beat registers
    logic                        r_sp;
    logic                        r_sok;
    logic signed [TEMP_WIDTH-1:0] r_temp;
    logic                        r_btn;
    logic                        r_heat;
    logic                        r_wend;
    logic signed [pth_pkg::ERR_W-1:0] r_err;
    logic signed [pth_pkg::ERR_W-1:0] r_d;
    logic signed [pth_pkg::PROD_W-1:0] r_prod;
    logic signed [pth_pkg::ACC_W-1:0]  r_acc;
    logic                        r_o_heat;
    logic [pth_pkg::PCT_W-1:0]   r_o_pct;
    logic                        r_o_side;
    logic [pth_pkg::TURN_W-1:0]  r_o_turn;

    logic [pth_pkg::PC_W-1:0]    n_pc;

    pth_pkg::t_uword             w_uw;
    logic                        w_beat_in;
    logic                        w_beat_out;
    logic                        w_out_busy;
    logic                        w_fin_go;
    logic                        w_jump;
    logic signed [pth_pkg::TEMP_EXT_W-1:0] w_latest_x;
    logic signed [pth_pkg::TEMP_EXT_W-1:0] w_err_x;
    logic                        w_in_range;
    logic [pth_pkg::WIN_W:0]     w_wc_inc;
    logic signed [pth_pkg::SUM_W+1:0] w_sum;
    logic signed [pth_pkg::SUM_W+1:0] w_lim;
    logic signed [pth_pkg::SUM_W+1:0] w_neg_lim;
    logic signed [pth_pkg::SUM_W-1:0] w_esum_next;
    logic signed [pth_pkg::ERR_W:0]   w_d;
    logic signed [pth_pkg::MUL_A_W-1:0] w_ma;
    logic signed [pth_pkg::MUL_B_W-1:0] w_mb;
    logic signed [pth_pkg::PROD_W-1:0]  w_prod;
    logic signed [pth_pkg::ACC_W-1:0]   w_prod_x;
    logic [pth_pkg::ACC_W-1:0]   w_q;
    logic [pth_pkg::PCT_W-1:0]   w_pct_next;
    logic                        w_side1;
    logic [pth_pkg::TURN_W-1:0]  w_cnt1;
    logic                        w_side2;
    logic [pth_pkg::TURN_W-1:0]  w_cnt2;

    // handshake
    assign o_ready    = (r_pc == pth_pkg::PC_IDLE);
    assign w_beat_in  = i_valid && o_ready;
    assign w_beat_out = r_ovalid && i_ready;
    assign w_out_busy = r_ovalid && !i_ready;

    assign w_uw     = pth_pkg::ucode(r_pc);
    assign w_fin_go = (w_uw.op == pth_pkg::OP_FIN) && !w_out_busy;

    // range check and error against setpoint
    assign w_latest_x = {{EXT_PAD{r_latest[TEMP_WIDTH-1]}}, r_latest};
    assign w_in_range = (w_latest_x > pth_pkg::TEMP_EXT_W'(pth_pkg::TEMP_LO_EXCL))
                     && (w_latest_x < pth_pkg::TEMP_EXT_W'(pth_pkg::TEMP_HI_EXCL));
    assign w_err_x    = $signed({{(pth_pkg::TEMP_EXT_W-pth_pkg::TGT_W){1'b0}}, r_target})
                      - w_latest_x;

    // window position
    assign w_wc_inc = {1'b0, r_wc} + (pth_pkg::WIN_W+1)'(1);

    // integral with symmetric clamp, derivative
    assign w_sum = {{2{r_esum[pth_pkg::SUM_W-1]}}, r_esum} + {r_err[pth_pkg::ERR_W-1], r_err};
    assign w_lim = $signed({{(pth_pkg::SUM_W+2-pth_pkg::LIM_W){1'b0}}, r_limit});
    assign w_neg_lim = -w_lim;
    assign w_d   = {r_err[pth_pkg::ERR_W-1], r_err}
                 - {r_last_err[pth_pkg::ERR_W-1], r_last_err};

    always_comb begin
        if (w_sum > w_lim) begin
            w_esum_next = w_lim[pth_pkg::SUM_W-1:0];
        end else if (w_sum < w_neg_lim) begin
            w_esum_next = w_neg_lim[pth_pkg::SUM_W-1:0];
        end else begin
            w_esum_next = w_sum[pth_pkg::SUM_W-1:0];
        end
    end

    // shared multiplier operand select
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (w_uw.op)
            pth_pkg::OP_MULP: begin
                w_ma = $signed({1'b0, r_kp});
                w_mb = {{(pth_pkg::MUL_B_W-pth_pkg::ERR_W){r_err[pth_pkg::ERR_W-1]}}, r_err};
            end
            pth_pkg::OP_MULI: begin
                w_ma = $signed({1'b0, r_ki});
                w_mb = {{(pth_pkg::MUL_B_W-pth_pkg::SUM_W){r_esum[pth_pkg::SUM_W-1]}}, r_esum};
            end
            pth_pkg::OP_MULD: begin
                w_ma = $signed({1'b0, r_kd});
                w_mb = {{(pth_pkg::MUL_B_W-pth_pkg::ERR_W){r_d[pth_pkg::ERR_W-1]}}, r_d};
            end
            pth_pkg::OP_ONMUL: begin
                w_ma = $signed({{(pth_pkg::MUL_A_W-pth_pkg::WIN_W){1'b0}}, r_window});
                w_mb = $signed({{(pth_pkg::MUL_B_W-pth_pkg::PCT_W){1'b0}}, r_pct});
            end
            pth_pkg::OP_ONDIV: begin
                w_ma = pth_pkg::MUL_A_W'(pth_pkg::RECIP100);
                w_mb = r_prod[pth_pkg::MUL_B_W-1:0];
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_prod   = w_ma * w_mb;
    assign w_prod_x = {r_prod[pth_pkg::PROD_W-1], r_prod};

    // drive level: scale down and saturate
    assign w_q = r_acc >> PCT_SHIFT;
    always_comb begin
        if (r_acc <= 0) begin
            w_pct_next = '0;
        end else if (w_q > pth_pkg::ACC_W'(pth_pkg::PCT_MAX)) begin
            w_pct_next = pth_pkg::PCT_W'(pth_pkg::PCT_MAX);
        end else begin
            w_pct_next = w_q[pth_pkg::PCT_W-1:0];
        end
    end

    // tray turner: button first, then timer
    assign w_side1 = r_side ^ r_btn;
    assign w_cnt1  = r_btn ? '0 : r_turn;
    assign w_side2 = (w_cnt1 >= r_interval) ? ~w_side1 : w_side1;
    assign w_cnt2  = (w_cnt1 >= r_interval) ? '0 : w_cnt1;

    // jump condition
    always_comb begin
        unique case (w_uw.cond)
            pth_pkg::JMP_NEXT:      w_jump = 1'b0;
            pth_pkg::JMP_ALWAYS:    w_jump = 1'b1;
            pth_pkg::JMP_NO_BEAT:   w_jump = !w_beat_in;
            pth_pkg::JMP_NO_WEND:   w_jump = !r_wend;
            pth_pkg::JMP_OUT_RANGE: w_jump = !w_in_range;
            pth_pkg::JMP_OUT_BUSY:  w_jump = w_out_busy;
            default:                w_jump = 1'b1;
        endcase
        n_pc = w_jump ? w_uw.target : r_pc + pth_pkg::PC_W'(1);
    end

    // sequencer, configuration and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc       <= pth_pkg::PC_IDLE;
            r_target   <= pth_pkg::TGT_W'(600);
            r_kp       <= pth_pkg::GAIN_W'(20480);
            r_ki       <= pth_pkg::GAIN_W'(26);
            r_kd       <= pth_pkg::GAIN_W'(102400);
            r_limit    <= pth_pkg::LIM_W'(1600);
            r_window   <= pth_pkg::WIN_W'(100);
            r_interval <= pth_pkg::TURN_W'(720000);
            r_latest   <= '0;
            r_esum     <= '0;
            r_last_err <= '0;
            r_on       <= '0;
            r_wc       <= '0;
            r_pct      <= '0;
            r_turn     <= '0;
            r_side     <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            r_pc <= n_pc;

            if (i_cfg_we) begin
                unique case (pth_pkg::t_reg'(i_cfg_idx))
                    pth_pkg::REG_TARGET_TEMP:    r_target   <= i_cfg_data[pth_pkg::TGT_W-1:0];
                    pth_pkg::REG_KP_GAIN:        r_kp       <= i_cfg_data[pth_pkg::GAIN_W-1:0];
                    pth_pkg::REG_KI_GAIN:        r_ki       <= i_cfg_data[pth_pkg::GAIN_W-1:0];
                    pth_pkg::REG_KD_GAIN:        r_kd       <= i_cfg_data[pth_pkg::GAIN_W-1:0];
                    pth_pkg::REG_INTEGRAL_LIMIT: r_limit    <= i_cfg_data[pth_pkg::LIM_W-1:0];
                    pth_pkg::REG_WINDOW_TICKS:   r_window   <= i_cfg_data[pth_pkg::WIN_W-1:0];
                    pth_pkg::REG_TURN_INTERVAL:  r_interval <= i_cfg_data[pth_pkg::TURN_W-1:0];
                    default: ;
                endcase
            end

            // window count wraps at the window length
            if (w_uw.op == pth_pkg::OP_TICK) begin
                if (w_wc_inc >= {1'b0, r_window}) begin
                    r_wc <= '0;
                end else begin
                    r_wc <= w_wc_inc[pth_pkg::WIN_W-1:0];
                end
            end

            if (w_uw.op == pth_pkg::OP_ERR) begin
                r_esum     <= w_esum_next;
                r_last_err <= r_err;
            end

            if (w_uw.op == pth_pkg::OP_PCT) begin
                r_pct <= w_pct_next;
            end

            if (w_uw.op == pth_pkg::OP_ONSET) begin
                r_on <= r_prod[pth_pkg::RECIP_SHIFT+pth_pkg::WIN_W-1:pth_pkg::RECIP_SHIFT];
            end

            if (w_uw.op == pth_pkg::OP_OFF) begin
                r_on  <= '0;
                r_pct <= '0;
            end

            // tick wrap-up: turner, sample store
            if (w_fin_go) begin
                r_side <= w_side2;
                r_turn <= w_cnt2 + pth_pkg::TURN_W'(1);
                if (r_sp) begin
                    r_latest <= r_sok ? r_temp : FAIL_CODE;
                end
            end

            if (w_fin_go) begin
                r_ovalid <= 1'b1;
            end else if (w_beat_out) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // datapath scratch and result payload
    always_ff @(posedge i_clk) begin
        if (w_beat_in) begin
            r_sp   <= i_sample_present;
            r_sok  <= i_sample_ok;
            r_temp <= i_temperature;
            r_btn  <= i_button_press;
        end

        if (w_uw.op == pth_pkg::OP_TICK) begin
            r_heat <= (r_wc < r_on);
            r_wend <= (w_wc_inc >= {1'b0, r_window});
        end

        if (w_uw.op == pth_pkg::OP_LOADE) begin
            r_err <= w_err_x[pth_pkg::ERR_W-1:0];
        end

        if (w_uw.op == pth_pkg::OP_ERR) begin
            r_d <= w_d[pth_pkg::ERR_W-1:0];
        end

        case (w_uw.op) inside
            pth_pkg::OP_MULP, pth_pkg::OP_MULD, pth_pkg::OP_ONMUL, pth_pkg::OP_ONDIV: begin
                r_prod <= w_prod;
            end
            pth_pkg::OP_MULI: begin
                r_prod <= w_prod;
                r_acc  <= w_prod_x;
            end
            default: ;
        endcase

        if (w_uw.op == pth_pkg::OP_MULD || w_uw.op == pth_pkg::OP_SUM) begin
            r_acc <= r_acc + w_prod_x;
        end

        if (w_fin_go) begin
            r_o_heat <= r_heat;
            r_o_pct  <= r_pct;
            r_o_side <= w_side2;
            r_o_turn <= w_cnt2 + pth_pkg::TURN_W'(1);
        end
    end

    assign o_valid          = r_ovalid;
    assign o_heater_on      = r_o_heat;
    assign o_heater_percent = r_o_pct;
    assign o_turn_side      = r_o_side;
    assign o_turn_angle     = r_o_side ? ANGLE_RIGHT : '0;
    assign o_turn_age       = r_o_turn;

endmodule

/* design/pth_checker.sv */
`timescale 1ns / 1ps

module pth_checker #(
    parameter int RIGHT_ANGLE = 60
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_valid,
    input logic                           o_ready,
    input logic                           o_valid,
    input logic                           i_ready,
    input logic                           o_heater_on,
    input logic [pth_pkg::PCT_W-1:0]      o_heater_percent,
    input logic                           o_turn_side,
    input logic [pth_pkg::ANGLE_W-1:0]    o_turn_angle,
    input logic [pth_pkg::TURN_W-1:0]     o_turn_age
);

    localparam logic [pth_pkg::ANGLE_W-1:0] ANGLE_RIGHT = pth_pkg::ANGLE_W'(RIGHT_ANGLE);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_heater_on) && $stable(o_heater_percent)
            && $stable(o_turn_side) && $stable(o_turn_age))
        else $error("result beat changed while stalled");

    // one tick in flight: no new beat right after one is taken
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("input taken while a tick is in work");

    // drive level saturates at full scale
    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_heater_percent <= pth_pkg::PCT_W'(pth_pkg::PCT_MAX))
        else $error("drive level above full scale");

    // servo angle follows the side
    a_angle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_turn_angle == (o_turn_side ? ANGLE_RIGHT : '0))
        else $error("turn angle does not match side");

    // the count always includes the current tick
    a_turn_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_turn_age != '0)
        else $error("tick count since turn is zero");

endmodule

bind pid_time_proportional_heater pth_checker #(
    .RIGHT_ANGLE(RIGHT_ANGLE)
) u_pth_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_valid            (i_valid),
    .o_ready            (o_ready),
    .o_valid            (o_valid),
    .i_ready            (i_ready),
    .o_heater_on        (o_heater_on),
    .o_heater_percent   (o_heater_percent),
    .o_turn_side        (o_turn_side),
    .o_turn_angle       (o_turn_angle),
    .o_turn_age         (o_turn_age)
);

/* tb/pid_time_proportional_heater_test.sv */
`timescale 1ns / 1ps

module pid_time_proportional_heater_test;

    localparam int TEMP_BITS     = 12;
    localparam int PID_SHIFT     = 8 + 4;  // gain fraction bits plus 1/16 C
    localparam int ANGLE_RIGHT   = 60;
    localparam int SETTLE_CYCLES = 20;     // longest tick is a pid window end
    localparam int CYCLE_LIMIT   = 200000;

    typedef struct packed {
        logic                        heat_on;
        logic [pth_pkg::PCT_W-1:0]   percent;
        logic                        side;
        logic [pth_pkg::ANGLE_W-1:0] angle;
        logic [pth_pkg::TURN_W-1:0]  since_turn;
    } t_heater_beat;

    typedef enum {SET_TYPICAL, SET_LOWEST, SET_HIGHEST} t_settings_kind;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_cfg_we = 1'b0;
    logic [pth_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [pth_pkg::CFG_W-1:0]     i_cfg_data = '0;
    logic                          i_valid = 1'b0;
    logic                          o_ready;
    logic                          i_sample_present = 1'b0;
    logic                          i_sample_ok = 1'b0;
    logic signed [TEMP_BITS-1:0]   i_temperature = '0;
    logic                          i_button_press = 1'b0;
    logic                          o_valid;
    logic                          i_ready = 1'b0;
    logic                          o_heater_on;
    logic [pth_pkg::PCT_W-1:0]     o_heater_percent;
    logic                          o_turn_side;
    logic [pth_pkg::ANGLE_W-1:0]   o_turn_angle;
    logic [pth_pkg::TURN_W-1:0]    o_turn_age;

    // controller settings as the predictor sees them
    logic [pth_pkg::TGT_W-1:0]  tgt_temp;
    logic [pth_pkg::GAIN_W-1:0] gain_p, gain_i, gain_d;
    logic [pth_pkg::LIM_W-1:0]  sum_limit;
    logic [pth_pkg::WIN_W-1:0]  win_len;
    logic [pth_pkg::TURN_W-1:0] turn_period;

    // controller state as the predictor sees it
    logic signed [TEMP_BITS-1:0]      held_temp;
    logic signed [pth_pkg::SUM_W-1:0] err_sum;
    logic signed [pth_pkg::ERR_W-1:0] prev_err;
    logic [pth_pkg::WIN_W-1:0]        on_len;
    logic [pth_pkg::WIN_W-1:0]        win_pos;
    logic [pth_pkg::PCT_W-1:0]        drive_pct;
    logic [pth_pkg::TURN_W-1:0]       since_turn;
    logic                             tray_side;

    t_heater_beat expected_beats[$];
    int error_count = 0;
    int cycle_count = 0;

    // idling controls, shared by the test tasks and the output side process
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_req = 0;
    int hold_len = 0;
    int hold_ack = 0;
    int hold_left = 0;

    pid_time_proportional_heater u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_sample_present   (i_sample_present),
        .i_sample_ok        (i_sample_ok),
        .i_temperature      (i_temperature),
        .i_button_press     (i_button_press),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_heater_on        (o_heater_on),
        .o_heater_percent   (o_heater_percent),
        .o_turn_side        (o_turn_side),
        .o_turn_angle       (o_turn_angle),
        .o_turn_age         (o_turn_age)
    );

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("end of test: mismatches");
        $finish;
    end

    // ---------------------------------------------------------------- predictor

    function automatic void clear_controller();
        tgt_temp    = 10'd600;
        gain_p      = 20'd20480;
        gain_i      = 20'd26;
        gain_d      = 20'd102400;
        sum_limit   = 11'd1600;
        win_len     = 8'd100;
        turn_period = 24'd720000;
        held_temp   = '0;
        err_sum     = '0;
        prev_err    = '0;
        on_len      = '0;
        win_pos     = '0;
        drive_pct   = '0;
        since_turn  = '0;
        tray_side   = 1'b0;
    endfunction

    // pid at window end, or heater off when the held temperature is out of range
    function automatic void update_drive_level();
        longint err, lim, acc, diff, pid_sum, pct;
        if (!(held_temp > pth_pkg::TEMP_LO_EXCL && held_temp < pth_pkg::TEMP_HI_EXCL)) begin
            on_len    = '0;
            drive_pct = '0;
            return;
        end
        err = longint'(tgt_temp) - longint'(held_temp);
        lim = longint'(sum_limit);
        acc = longint'(err_sum) + err;
        if (acc > lim) acc = lim;
        if (acc < -lim) acc = -lim;
        err_sum  = acc[pth_pkg::SUM_W-1:0];
        diff     = err - longint'(prev_err);
        prev_err = err[pth_pkg::ERR_W-1:0];
        pid_sum = longint'(gain_p) * err + longint'(gain_i) * longint'(err_sum)
                + longint'(gain_d) * diff;
        if (pid_sum <= 0) begin
            pct = 0;
        end else begin
            pct = pid_sum >>> PID_SHIFT;
            if (pct > pth_pkg::PCT_MAX) pct = pth_pkg::PCT_MAX;
        end
        drive_pct = pct[pth_pkg::PCT_W-1:0];
        on_len    = 8'((pct * longint'(win_len)) / 100);
    endfunction

    // one tick through the controller, returns the result beat it causes
    function automatic t_heater_beat advance_controller(input logic present, input logic ok,
                                                        input logic signed [TEMP_BITS-1:0] temp,
                                                        input logic press);
        t_heater_beat beat;
        logic [pth_pkg::WIN_W:0] next_pos;
        beat.heat_on = (on_len != 0) && (win_pos < on_len);
        next_pos = win_pos + 1'b1;
        if (next_pos >= win_len) begin
            win_pos = '0;
            update_drive_level();
        end else begin
            win_pos = next_pos[pth_pkg::WIN_W-1:0];
        end
        if (press) begin
            tray_side  = ~tray_side;
            since_turn = '0;
        end
        if (since_turn >= turn_period) begin
            tray_side  = ~tray_side;
            since_turn = '0;
        end
        if (present) held_temp = ok ? temp : TEMP_BITS'(pth_pkg::FAIL_TEMP);
        since_turn = since_turn + 1'b1;
        beat.percent    = drive_pct;
        beat.side       = tray_side;
        beat.angle      = tray_side ? pth_pkg::ANGLE_W'(ANGLE_RIGHT) : '0;
        beat.since_turn = since_turn;
        return beat;
    endfunction

    // ---------------------------------------------------------------- checking

    function automatic void flag_error(input string msg);
        error_count++;
        if (error_count <= 10) $display("%s", msg);
    endfunction

    function automatic void check_field(input string name, input longint want, input longint got);
        if (want != got)
            flag_error($sformatf("mismatch on %s: expected %0d, got %0d", name, want, got));
    endfunction

    always @(posedge i_clk) begin
        t_heater_beat want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_beats.size() == 0) begin
                flag_error("result beat arrived with nothing expected");
            end else begin
                want = expected_beats.pop_front();
                check_field("heater_on", longint'(want.heat_on), longint'(o_heater_on));
                check_field("heater_percent", longint'(want.percent),
                            longint'(o_heater_percent));
                check_field("turn_side", longint'(want.side), longint'(o_turn_side));
                check_field("turn_angle", longint'(want.angle), longint'(o_turn_angle));
                check_field("turn_age", longint'(want.since_turn), longint'(o_turn_age));
            end
        end
    end

    // output side: random stalls plus an occasional long hold-off
    always @(posedge i_clk) begin
        if (hold_req != hold_ack) begin
            hold_ack  = hold_req;
            hold_left = hold_len;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ---------------------------------------------------------------- drivers

    task automatic cfg_write(input pth_pkg::t_reg idx, input int value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= pth_pkg::CFG_W'(value);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            pth_pkg::REG_TARGET_TEMP:    tgt_temp    = value[pth_pkg::TGT_W-1:0];
            pth_pkg::REG_KP_GAIN:        gain_p      = value[pth_pkg::GAIN_W-1:0];
            pth_pkg::REG_KI_GAIN:        gain_i      = value[pth_pkg::GAIN_W-1:0];
            pth_pkg::REG_KD_GAIN:        gain_d      = value[pth_pkg::GAIN_W-1:0];
            pth_pkg::REG_INTEGRAL_LIMIT: sum_limit   = value[pth_pkg::LIM_W-1:0];
            pth_pkg::REG_WINDOW_TICKS:   win_len     = value[pth_pkg::WIN_W-1:0];
            pth_pkg::REG_TURN_INTERVAL:  turn_period = value[pth_pkg::TURN_W-1:0];
            default: ;
        endcase
    endtask

    // one tick beat; valid stays up between back-to-back beats
    task automatic send_tick(input logic present, input logic ok,
                             input logic signed [TEMP_BITS-1:0] temp, input logic press);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_valid          <= 1'b1;
        i_sample_present <= present;
        i_sample_ok      <= ok;
        i_temperature    <= temp;
        i_button_press   <= press;
        do @(posedge i_clk); while (!o_ready);
        expected_beats.push_back(advance_controller(present, ok, temp, press));
    endtask

    // mostly plausible readings near the setpoint, some at the range edges, some noise
    task automatic send_random_tick();
        int pick;
        int t;
        pick = $urandom_range(99);
        if (pick < 50)      t = int'(tgt_temp) + int'($urandom_range(60)) - 40;
        else if (pick < 80) t = $urandom_range(959, 81);
        else if (pick < 90) t = ($urandom_range(1) ? 80 : 960) + int'($urandom_range(4)) - 2;
        else                t = $urandom_range(4095);
        send_tick($urandom_range(99) < 45, $urandom_range(99) < 90, TEMP_BITS'(t),
                  $urandom_range(99) < 6);
    endtask

    task automatic wait_until_idle();
        i_valid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic int pick_gain(input int scale);
        if ($urandom_range(3) == 0) return int'($urandom_range(1048575));
        return int'($urandom_range(scale));
    endfunction

    task automatic load_settings(input t_settings_kind kind);
        case (kind)
            SET_LOWEST: begin
                cfg_write(pth_pkg::REG_TARGET_TEMP, 0);
                cfg_write(pth_pkg::REG_KP_GAIN, 0);
                cfg_write(pth_pkg::REG_KI_GAIN, 0);
                cfg_write(pth_pkg::REG_KD_GAIN, 0);
                cfg_write(pth_pkg::REG_INTEGRAL_LIMIT, 0);
                cfg_write(pth_pkg::REG_WINDOW_TICKS, 1);
                cfg_write(pth_pkg::REG_TURN_INTERVAL, 1);
            end
            SET_HIGHEST: begin
                cfg_write(pth_pkg::REG_TARGET_TEMP, 1023);
                cfg_write(pth_pkg::REG_KP_GAIN, 1048575);
                cfg_write(pth_pkg::REG_KI_GAIN, 1048575);
                cfg_write(pth_pkg::REG_KD_GAIN, 1048575);
                cfg_write(pth_pkg::REG_INTEGRAL_LIMIT, 2047);
                cfg_write(pth_pkg::REG_WINDOW_TICKS, 3);
                cfg_write(pth_pkg::REG_TURN_INTERVAL, 16777215);
            end
            default: begin
                cfg_write(pth_pkg::REG_TARGET_TEMP, int'($urandom_range(900, 300)));
                cfg_write(pth_pkg::REG_KP_GAIN, pick_gain(40000));
                cfg_write(pth_pkg::REG_KI_GAIN, pick_gain(2000));
                cfg_write(pth_pkg::REG_KD_GAIN, pick_gain(200000));
                cfg_write(pth_pkg::REG_INTEGRAL_LIMIT, int'($urandom_range(2047)));
                cfg_write(pth_pkg::REG_WINDOW_TICKS, int'($urandom_range(12, 1)));
                cfg_write(pth_pkg::REG_TURN_INTERVAL, int'($urandom_range(40, 1)));
            end
        endcase
    endtask

    // ---------------------------------------------------------------- tests

    // register defaults straight out of reset
    task automatic test_reset_state();
        send_tick(1'b1, 1'b1, 12'sd600, 1'b0);
        send_tick(1'b0, 1'b0, 12'sd0, 1'b0);
        wait_until_idle();
    endtask

    // valid range edges, failed readings, ignored ok flag, temperature extremes
    task automatic test_temperature_range();
        cfg_write(pth_pkg::REG_INTEGRAL_LIMIT, 2047);
        cfg_write(pth_pkg::REG_WINDOW_TICKS, 1);
        cfg_write(pth_pkg::REG_TURN_INTERVAL, 5);
        send_tick(1'b1, 1'b1, 12'sd80, 1'b0);
        send_tick(1'b0, 1'b0, 12'sd0, 1'b0);
        send_tick(1'b1, 1'b1, 12'sd81, 1'b0);
        send_tick(1'b1, 1'b1, 12'sd959, 1'b0);
        send_tick(1'b1, 1'b1, 12'sd960, 1'b0);
        send_tick(1'b1, 1'b0, 12'sd500, 1'b0);
        send_tick(1'b0, 1'b1, 12'sd500, 1'b0);
        send_tick(1'b1, 1'b1, 12'sd2047, 1'b1);
        send_tick(1'b1, 1'b1, -12'sd2048, 1'b0);
        send_tick(1'b1, 1'b1, 12'sd598, 1'b1);
        send_tick(1'b0, 1'b0, -12'sd1, 1'b0);
        wait_until_idle();
        // negative error drives the pid sum below zero
        cfg_write(pth_pkg::REG_TARGET_TEMP, 0);
        send_tick(1'b1, 1'b1, 12'sd900, 1'b0);
        send_tick(1'b0, 1'b0, 12'sd0, 1'b0);
        wait_until_idle();
    endtask

    // zero-length window, zero turn interval, window shortened mid-window
    task automatic test_corner_settings();
        cfg_write(pth_pkg::REG_TARGET_TEMP, 600);
        cfg_write(pth_pkg::REG_WINDOW_TICKS, 0);
        send_tick(1'b1, 1'b1, 12'sd500, 1'b0);
        send_tick(1'b0, 1'b0, 12'sd0, 1'b0);
        wait_until_idle();
        cfg_write(pth_pkg::REG_WINDOW_TICKS, 5);
        cfg_write(pth_pkg::REG_TURN_INTERVAL, 0);
        send_tick(1'b0, 1'b1, 12'sd0, 1'b0);
        send_tick(1'b0, 1'b0, 12'sd0, 1'b1);
        wait_until_idle();
        cfg_write(pth_pkg::REG_TURN_INTERVAL, 16777215);
        cfg_write(pth_pkg::REG_WINDOW_TICKS, 255);
        repeat (4) send_tick(1'b1, 1'b1, 12'sd520, 1'b0);
        wait_until_idle();
        cfg_write(pth_pkg::REG_WINDOW_TICKS, 2);
        send_tick(1'b0, 1'b0, 12'sd0, 1'b0);
        send_tick(1'b0, 1'b0, 12'sd0, 1'b0);
        wait_until_idle();
    endtask

    task automatic run_traffic(input int send_pct, input int recv_pct,
                               input t_settings_kind kind, input int count);
        load_settings(kind);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        repeat (count) send_random_tick();
        wait_until_idle();
    endtask

    task automatic test_random_traffic();
        run_traffic(0, 0, SET_TYPICAL, 90);
        run_traffic(75, 0, SET_HIGHEST, 80);
        run_traffic(0, 75, SET_TYPICAL, 80);
        run_traffic(30, 30, SET_LOWEST, 80);
        run_traffic(30, 30, SET_TYPICAL, 50);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    // long output hold-off while beats keep coming, so the input stalls
    task automatic test_output_hold_off();
        load_settings(SET_TYPICAL);
        hold_len = 200;
        hold_req = hold_req + 1;
        repeat (20) send_random_tick();
        wait_until_idle();
    endtask

    // sender stops until every result is back, then resumes
    task automatic test_sender_pause();
        repeat (10) send_random_tick();
        i_valid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge i_clk);
        repeat (10) send_random_tick();
        wait_until_idle();
    endtask

    initial begin
        clear_controller();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_state();
        test_temperature_range();
        test_corner_settings();
        test_random_traffic();
        test_output_hold_off();
        test_sender_pause();
        if (error_count == 0 && expected_beats.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
